// ===== sv/cx32_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cx32_pkg
// Shared types, codes and constant tables of the codex32 BCH checksum engine.
// ----------------------------------------------------------------------------
package cx32_pkg;

	typedef logic [4:0] sym_t;
	typedef logic [3:0] idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_VERIFY,
		ST_EMIT
	} cx32_state_t;

	localparam logic [1:0] KIND_ABSORB = 2'd0;
	localparam logic [1:0] KIND_VERIFY = 2'd1;
	localparam logic [1:0] KIND_GEN    = 2'd2;

	localparam idx_t LAST_SHORT = 4'd12;
	localparam idx_t LAST_LONG  = 4'd14;
	localparam int   RES_DEPTH  = 15;

	// generator vectors, short code in row 0, long code in row 1
	localparam sym_t GEN_TAB [2][16] = '{
		'{5'd25, 5'd27, 5'd17, 5'd8,  5'd0,  5'd25, 5'd25, 5'd25,
		  5'd31, 5'd27, 5'd24, 5'd16, 5'd16, 5'd0,  5'd0,  5'd0},
		'{5'd15, 5'd10, 5'd25, 5'd26, 5'd9,  5'd25, 5'd21, 5'd6,
		  5'd23, 5'd21, 5'd6,  5'd5,  5'd22, 5'd4,  5'd23, 5'd0}
	};

	// residue targets: "secretshare32" and "secretshare32ex"
	localparam sym_t TGT_TAB [2][16] = '{
		'{5'd16, 5'd25, 5'd24, 5'd3,  5'd25, 5'd11, 5'd16, 5'd23,
		  5'd29, 5'd3,  5'd25, 5'd17, 5'd10, 5'd0,  5'd0,  5'd0},
		'{5'd16, 5'd25, 5'd24, 5'd3,  5'd25, 5'd11, 5'd16, 5'd23,
		  5'd29, 5'd3,  5'd25, 5'd17, 5'd10, 5'd25, 5'd6,  5'd0}
	};

	// GF(32) with field polynomial x^5 + x^3 + 1
	localparam logic [4:0] GF_LOG [32] = '{
		5'd0,  5'd0,  5'd1,  5'd14, 5'd2,  5'd28, 5'd15, 5'd22,
		5'd3,  5'd5,  5'd29, 5'd26, 5'd16, 5'd7,  5'd23, 5'd11,
		5'd4,  5'd25, 5'd6,  5'd10, 5'd30, 5'd13, 5'd27, 5'd21,
		5'd17, 5'd18, 5'd8,  5'd19, 5'd24, 5'd9,  5'd12, 5'd20
	};

	localparam sym_t GF_EXP [32] = '{
		5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd9,  5'd18, 5'd13,
		5'd26, 5'd29, 5'd19, 5'd15, 5'd30, 5'd21, 5'd3,  5'd6,
		5'd12, 5'd24, 5'd25, 5'd27, 5'd31, 5'd23, 5'd7,  5'd14,
		5'd28, 5'd17, 5'd11, 5'd22, 5'd5,  5'd10, 5'd20, 5'd0
	};

	function automatic idx_t last_index(input logic mode);
		return mode ? LAST_LONG : LAST_SHORT;
	endfunction

	// initial residue: all zero but a one in the final active entry
	function automatic sym_t init_entry(input logic mode, input idx_t i);
		return (i == last_index(mode)) ? 5'd1 : 5'd0;
	endfunction

endpackage

// ===== sv/codex32_bch_checksum_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codex32_bch_checksum_engine_unit
// Codex32 BCH checksum engine over GF(32), one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word: kind and symbol.
//   Kind absorb folds the symbol into the residue, kind verify returns one
//   word with checksum_ok, kind generate returns 13 or 15 checksum symbols
//   with last on the final one. Unused kind codes are taken and dropped.
//   Output channel (out_valid / out_stall) is fed from an output register, so
//   a new input word is taken while the previous result still waits.
//   Configuration channel (cfg_valid / cfg_ready) writes long_mode; it is
//   taken only while idle and resets the residue for the selected code.
// Sequencing (len = 13 short, 15 long):
//   Absorb: one residue entry per cycle through the shared GF multiplier,
//   so the input stalls until all len active entries are updated.
//   Verify: the residue is compared, and the result is loaded into the output register once it is free.
//   Generate: len absorbs of the target, then len words
//   at one per cycle while the receiver takes them.
// Reset: long_mode clears to the short code, residue to its initial pattern.
// A stalled receiver holds the output register and freezes emission; the
// block takes no input until the final word of its item is in that register.
// ----------------------------------------------------------------------------
module codex32_bch_checksum_engine_unit (
	input  logic           clk,
	input  logic           arst_n,
	// configuration
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           long_mode,
	// input words
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     kind,
	input  cx32_pkg::sym_t symbol,
	// result words
	output logic           out_valid,
	input  logic           out_stall,
	output logic           checksum_ok,
	output cx32_pkg::sym_t checksum_symbol,
	output logic           last
);
	import cx32_pkg::*;

	cx32_state_t state_q, state_d;

	logic mode_q;
	sym_t res_q [RES_DEPTH];
	idx_t idx_q;        // residue position in absorb, emit index in emit
	idx_t tcnt_q;       // target symbol count during generate
	logic gen_q;        // absorb belongs to a generate run
	sym_t sym_q;
	sym_t head_q;

	logic out_valid_q;
	logic ok_q;
	sym_t osym_q;
	logic last_q;

	idx_t last_idx;
	logic in_take;
	logic cfg_take;
	logic out_free;
	logic out_load;
	logic out_load_last;
	logic res_reinit;
	logic idx_at_last;
	logic verify_ok;
	idx_t rd_idx;
	sym_t rd_data;
	sym_t absorb_sym;
	sym_t absorb_src;
	sym_t gen_coef;
	sym_t gf_prod;

	assign last_idx    = last_index(mode_q);
	assign idx_at_last = (idx_q == last_idx);
	assign cfg_ready   = (state_q == ST_IDLE);
	// configuration has the port while it is presented
	assign in_stall    = (state_q != ST_IDLE) || cfg_valid;
	assign in_take     = in_valid && !in_stall;
	assign cfg_take    = cfg_valid && cfg_ready;
	assign out_free    = !out_valid_q || !out_stall;

	// read port into the residue, shared by absorb and emit
	assign rd_idx     = ((state_q == ST_ABSORB) && !idx_at_last) ? idx_q + 4'd1 : idx_q;
	assign rd_data    = res_q[rd_idx];
	assign absorb_sym = gen_q ? TGT_TAB[mode_q][tcnt_q] : sym_q;
	assign absorb_src = idx_at_last ? absorb_sym : rd_data;
	assign gen_coef   = GEN_TAB[mode_q][idx_q];

	cx32_gf_mul u_gf_mul (
		.a(gen_coef),
		.b(head_q),
		.p(gf_prod)
	);

	// compare the whole active residue against the target
	always_comb begin
		verify_ok = 1'b1;
		for (int i = 0; i < RES_DEPTH; i++) begin
			if ((4'(i) <= last_idx) && (res_q[i] != TGT_TAB[mode_q][i])) begin
				verify_ok = 1'b0;
			end
		end
	end

	// next state and sequencing strobes
	always_comb begin
		state_d       = state_q;
		out_load      = 1'b0;
		out_load_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					unique case (kind)
						KIND_ABSORB: state_d = ST_ABSORB;
						KIND_VERIFY: state_d = ST_VERIFY;
						KIND_GEN:    state_d = ST_ABSORB;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_ABSORB: begin
				if (idx_at_last) begin
					if (!gen_q) begin
						state_d = ST_IDLE;
					end else if (tcnt_q == last_idx) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_VERIFY: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_load_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_load_last = idx_at_last;
					if (idx_at_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res_reinit = cfg_take || out_load_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			idx_q  <= '0;
			tcnt_q <= '0;
			gen_q  <= 1'b0;
		end else begin
			if (cfg_take) begin
				mode_q <= long_mode;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					tcnt_q <= '0;
					if (in_take) begin
						gen_q <= (kind == KIND_GEN);
					end
				end
				ST_ABSORB: begin
					if (idx_at_last) begin
						idx_q  <= '0;
						tcnt_q <= tcnt_q + 4'd1;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				ST_VERIFY: begin
					idx_q <= '0;
				end
				ST_EMIT: begin
					if (out_load) begin
						idx_q <= idx_at_last ? 4'd0 : idx_q + 4'd1;
					end
				end
				default: idx_q <= '0;
			endcase
		end
	end

	// symbol and head element of the absorb in progress
	always_ff @(posedge clk) begin
		if (in_take) begin
			sym_q  <= symbol;
			head_q <= res_q[0];
		end else if ((state_q == ST_ABSORB) && idx_at_last) begin
			// entry 0 is already updated, so it is the next head
			head_q <= res_q[0];
		end
	end

	// residue: reset and reinit load the initial pattern; absorb updates one entry per cycle through the shared multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RES_DEPTH; i++) begin
				res_q[i] <= init_entry(1'b0, 4'(i));
			end
		end else if (res_reinit) begin
			for (int i = 0; i < RES_DEPTH; i++) begin
				res_q[i] <= init_entry(cfg_take ? long_mode : mode_q, 4'(i));
			end
		end else if (state_q == ST_ABSORB) begin
			res_q[idx_q] <= absorb_src ^ gf_prod;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_VERIFY) begin
				ok_q   <= verify_ok;
				osym_q <= '0;
				last_q <= 1'b1;
			end else begin
				ok_q   <= 1'b0;
				osym_q <= rd_data;
				last_q <= idx_at_last;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign checksum_ok     = ok_q;
	assign checksum_symbol = osym_q;
	assign last            = last_q;

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (idx_q <= last_idx))
		else $error("residue index beyond active length");

	a_result_kinds_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(checksum_ok && (checksum_symbol != 5'd0)))
		else $error("verify and generate fields both set");

	a_run_resets_residue: assert property (@(posedge clk) disable iff (!arst_n)
		out_load_last |=> (res_q[last_idx] == 5'd1) && (res_q[0] == 5'd0))
		else $error("residue not reinitialized after run");

	a_emit_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && out_load && idx_at_last) |=> (state_q == ST_IDLE))
		else $error("emission did not end after last symbol");
`endif

endmodule

// ===== sv/cx32_gf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cx32_gf_mul
// GF(32) multiplier through log and antilog tables.
// ----------------------------------------------------------------------------
module cx32_gf_mul (
	input  cx32_pkg::sym_t a,
	input  cx32_pkg::sym_t b,
	output cx32_pkg::sym_t p
);
	import cx32_pkg::*;

	logic [5:0] log_sum;
	logic [4:0] log_mod;

	always_comb begin
		log_sum = {1'b0, GF_LOG[a]} + {1'b0, GF_LOG[b]};
		// sum stays below 62, so one subtract reduces it mod 31
		log_mod = (log_sum >= 6'd31) ? 5'(log_sum - 6'd31) : log_sum[4:0];
		p       = ((a == 5'd0) || (b == 5'd0)) ? 5'd0 : GF_EXP[log_mod];
	end

endmodule
